// File: hw/rtl/sb1d_pkg.sv
`timescale 1ns / 1ps
package sb1d_pkg;

  // fixed field widths
  localparam int unsigned SAMPLE_BITS = 8;
  localparam int unsigned RADIUS_W = 4;
  localparam int unsigned SEEN_W = 4;

  // defaults, reset values and limits
  localparam int unsigned MAX_RADIUS_DEF = 8;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 4'd2;
  localparam logic [SEEN_W-1:0] SEEN_MAX = 4'd15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_TAIL,
    ST_DIV,
    ST_EMIT
  } state_e;

endpackage

// File: hw/rtl/sb1d_in_if.sv
`timescale 1ns / 1ps
interface sb1d_in_if;
  logic                             valid;
  logic                             ready;
  logic [sb1d_pkg::SAMPLE_BITS-1:0] sample;
  logic                             last_in;

  modport source (output valid, output sample, output last_in, input ready);
  modport sink (input valid, input sample, input last_in, output ready);
endinterface

// File: hw/rtl/sb1d_out_if.sv
`timescale 1ns / 1ps
interface sb1d_out_if;
  logic                             valid;
  logic                             ready;
  logic [sb1d_pkg::SAMPLE_BITS-1:0] blurred;
  logic                             last_out;

  modport source (output valid, output blurred, output last_out, input ready);
  modport sink (input valid, input blurred, input last_out, output ready);
endinterface

// File: hw/rtl/sb1d_cfg_if.sv
`timescale 1ns / 1ps
interface sb1d_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sb1d_pkg::RADIUS_W-1:0] radius;

  modport source (output valid, output radius, input ready);
  modport sink (input valid, input radius, output ready);
endinterface

// File: hw/rtl/sb1d_div.sv
`timescale 1ns / 1ps
module sb1d_div #(
  parameter int unsigned MAX_RADIUS = sb1d_pkg::MAX_RADIUS_DEF,
  localparam int unsigned DIV_W = $clog2((MAX_RADIUS + 1) * (MAX_RADIUS + 1) + 1),
  localparam int unsigned SUM_W =
    $clog2((MAX_RADIUS + 1) * (MAX_RADIUS + 1) * ((1 << sb1d_pkg::SAMPLE_BITS) - 1) + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [SUM_W-1:0]                 dividend_i,
  input  logic [DIV_W-1:0]                 divisor_i,
  output logic                             done_o,
  output logic [sb1d_pkg::SAMPLE_BITS-1:0] quot_o
);
  import sb1d_pkg::*;

  localparam int unsigned REM_W = DIV_W + SAMPLE_BITS;
  localparam int unsigned CNT_W = $clog2(SAMPLE_BITS + 1);

  logic [REM_W-1:0]       rem_q;
  logic [REM_W-1:0]       den_q;
  logic [SAMPLE_BITS-1:0] quot_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   busy_q;
  logic                   done_q;
  logic                   ge;

  // quotient is known to fit in SAMPLE_BITS, so start with the divisor
  // aligned to the top quotient bit
  assign ge = rem_q >= den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(SAMPLE_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= REM_W'(dividend_i);
      den_q  <= REM_W'(divisor_i) << (SAMPLE_BITS - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - den_q;
      end
      den_q  <= den_q >> 1;
      quot_q <= SAMPLE_BITS'({quot_q, ge});
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: hw/rtl/stack_blur_1d.sv
`timescale 1ns / 1ps
// a result word passes ST_ACC, ST_TAIL, ST_DIV and ST_EMIT; no input is taken meanwhile
// each result takes 2r+1 ring reads, a weighted accumulate, a bit-serial divide and an output load
// a word that yields no result leaves the block idle; the last word of a line yields up to r+1
// throughput is bound by the single read port of the sample ring and the bit-serial divider
// reset: radius goes to 2, streaming state clears, ring entries read as zero via valid bits
module stack_blur_1d #(
  parameter int unsigned MAX_RADIUS = sb1d_pkg::MAX_RADIUS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sb1d_cfg_if.sink   cfg_i,
  sb1d_in_if.sink    in_i,
  sb1d_out_if.source out_o
);
  import sb1d_pkg::*;

  localparam int unsigned DEPTH = 2 * MAX_RADIUS + 1;
  localparam int unsigned AW = $clog2(DEPTH);
  // index arithmetic needs one extra bit for the wrap
  localparam int unsigned CW = AW + 1;
  // weight is at most r+1
  localparam int unsigned W_W = $clog2(MAX_RADIUS + 2);
  localparam int unsigned DIV_W = $clog2((MAX_RADIUS + 1) * (MAX_RADIUS + 1) + 1);
  localparam int unsigned SUM_W =
    $clog2((MAX_RADIUS + 1) * (MAX_RADIUS + 1) * ((1 << SAMPLE_BITS) - 1) + 1);

  // ---------------------------------------------------------------
  // state
  // ---------------------------------------------------------------
  state_e state_q, state_d;

  logic [RADIUS_W-1:0]    radius_q;
  logic [AW-1:0]          pos_q;        // next ring slot to write
  logic [SEEN_W-1:0]      seen_q;       // words of this line, saturating
  logic [DEPTH-1:0]       ring_vld_q;   // entries written since the line began
  logic [AW-1:0]          j_q;          // tap index within the window, 0..2r
  logic [RADIUS_W-1:0]    dc_q;         // centre offset back from the newest word
  logic                   flush_q;      // working through the tail of a line

  // sample ring, one write and one registered read per cycle
  logic [SAMPLE_BITS-1:0] ring_mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_q;
  logic                   rd_vld_q;

  // multiply-accumulate stage behind the ring read
  logic                   acc_vld_q;
  logic [W_W-1:0]         wt_q;
  logic [SUM_W-1:0]       wsum_q, wsum_d;

  // output register
  logic                   out_vld_q;
  logic [SAMPLE_BITS-1:0] blurred_q;
  logic                   last_q;

  // ---------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------
  logic in_ready, in_acc, cfg_acc, slot_free;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid & cfg_i.ready;
  // hold off input while a radius write is on the port
  assign in_ready    = (state_q == ST_IDLE) && !cfg_i.valid;
  assign in_i.ready  = in_ready;
  assign in_acc      = in_i.valid & in_ready;
  assign slot_free   = !out_vld_q || out_o.ready;

  // ---------------------------------------------------------------
  // radius clamp, tap addressing, weights and divisor
  // ---------------------------------------------------------------
  logic [RADIUS_W-1:0] r_eff;
  logic [CW-1:0]       r_ext, j_ext, span, absk, d_ext;
  logic [AW-1:0]       d, newest, rd_addr;
  logic [W_W-1:0]      weight, r1;
  logic [DIV_W-1:0]    divisor;

  assign r_eff = (radius_q > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius_q;
  assign r_ext = CW'(r_eff);
  assign j_ext = CW'(j_q);
  assign span  = CW'(dc_q) + r_ext;

  // taps newer than the newest word repeat it
  assign d_ext = (j_ext > span) ? '0 : span - j_ext;
  assign d     = AW'(d_ext);

  // triangular weight r+1-|k| with k = j-r
  assign absk   = (j_ext < r_ext) ? r_ext - j_ext : j_ext - r_ext;
  assign weight = W_W'(r_ext + CW'(1) - absk);

  assign newest  = (pos_q == '0) ? AW'(DEPTH - 1) : pos_q - AW'(1);
  assign rd_addr = (newest >= d) ? newest - d
                                 : AW'(CW'(newest) + CW'(DEPTH) - CW'(d));

  assign r1      = W_W'(r_ext + CW'(1));
  assign divisor = DIV_W'(r1) * DIV_W'(r1);

  // ---------------------------------------------------------------
  // control
  // ---------------------------------------------------------------
  logic                div_done;
  logic [SAMPLE_BITS-1:0] div_quot;
  logic                start_acc, issue, div_start, emit, line_clr;
  logic [RADIUS_W-1:0] dc_d;
  logic                flush_d;
  logic                want_out;
  logic                last_tap;

  assign want_out = in_i.last_in || (seen_q >= r_eff);
  assign last_tap = (j_q == AW'(r_ext << 1));

  always_comb begin
    state_d   = state_q;
    start_acc = 1'b0;
    issue     = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    line_clr  = cfg_acc;
    dc_d      = dc_q;
    flush_d   = flush_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          flush_d = in_i.last_in;
          // on the last word, flush every centre still pending
          if (in_i.last_in) begin
            dc_d = (seen_q < r_eff) ? seen_q : r_eff;
          end else begin
            dc_d = r_eff;
          end
          if (want_out) begin
            start_acc = 1'b1;
            state_d   = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        issue = 1'b1;
        if (last_tap) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        // last product lands in wsum_d this cycle
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          emit = 1'b1;
          if (flush_q && (dc_q != '0)) begin
            dc_d      = dc_q - RADIUS_W'(1);
            start_acc = 1'b1;
            state_d   = ST_ACC;
          end else begin
            line_clr = line_clr | flush_q;
            state_d  = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------
  // line state: radius, ring position, valid bits, word count
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= RADIUS_RST;
      pos_q      <= '0;
      seen_q     <= '0;
      ring_vld_q <= '0;
      dc_q       <= '0;
      flush_q    <= 1'b0;
      j_q        <= '0;
      acc_vld_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (cfg_acc) begin
        radius_q <= cfg_i.radius;
      end
      if (line_clr) begin
        pos_q      <= '0;
        seen_q     <= '0;
        ring_vld_q <= '0;
      end else if (in_acc) begin
        ring_vld_q[pos_q] <= 1'b1;
        pos_q  <= (pos_q == AW'(DEPTH - 1)) ? '0 : pos_q + AW'(1);
        if (seen_q != SEEN_MAX) begin
          seen_q <= seen_q + SEEN_W'(1);
        end
      end
      dc_q    <= dc_d;
      flush_q <= flush_d;
      if (start_acc) begin
        j_q <= '0;
      end else if (issue) begin
        j_q <= j_q + AW'(1);
      end
      acc_vld_q <= issue;
      // never-written entries of this line read as zero
      rd_vld_q  <= ring_vld_q[rd_addr];
    end
  end

  // ring write on accept, read every cycle; accepts and issued tap reads never share a cycle
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ring_mem[pos_q] <= in_i.sample;
    end
    rd_data_q <= ring_mem[rd_addr];
  end

  // ---------------------------------------------------------------
  // weighted sum
  // ---------------------------------------------------------------
  logic [SAMPLE_BITS-1:0]     tap_val;
  logic [W_W+SAMPLE_BITS-1:0] term;

  assign tap_val = rd_vld_q ? rd_data_q : '0;
  assign term    = wt_q * tap_val;
  assign wsum_d  = acc_vld_q ? wsum_q + SUM_W'(term) : wsum_q;

  always_ff @(posedge clk_i) begin
    wt_q <= weight;
    if (start_acc) begin
      wsum_q <= '0;
    end else begin
      wsum_q <= wsum_d;
    end
  end

  // ---------------------------------------------------------------
  // divide by (r+1)^2
  // ---------------------------------------------------------------
  sb1d_div #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (wsum_d),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // ---------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      blurred_q <= div_quot;
      last_q    <= flush_q && (dc_q == '0);
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.blurred  = blurred_q;
  assign out_o.last_out = last_q;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
`ifndef SYNTHESIS
  a_line_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && slot_free && flush_q && dc_q == '0)
    |=> (pos_q == '0 && seen_q == '0 && ring_vld_q == '0))
    else $error("line state not cleared after final word");

  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |-> (CW'(rd_addr) < CW'(DEPTH)))
    else $error("ring read address out of range");

  a_weight_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |-> (weight != '0))
    else $error("zero tap weight inside window");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside divide state");
`endif

endmodule
